### sv/vtpd_pkg.sv
package vtpd_pkg;

  localparam int NUM_ROWS   = 4;
  localparam int NUM_COLS   = 3;
  localparam int LANE_W     = 16;
  localparam int ROW_W      = 64;
  localparam int COORD_W    = 32;
  localparam int PROD_W     = LANE_W + COORD_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int QUOT_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0 = 8'd0,
    CFG_ROW1 = 8'd1,
    CFG_ROW2 = 8'd2,
    CFG_ROW3 = 8'd3
  } cfg_reg_t;

  // identity matrix after reset
  localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

  localparam logic [QUOT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QUOT_W-1:0] SAT_NEG = 32'h8000_0000;

  // side information carried along the divider stages
  typedef struct packed {
    logic vld;
    logic neg;
    logic ovf;
    logic zro;
  } div_meta_t;

endpackage

### sv/vtpd_div.sv
module vtpd_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic signed [vtpd_pkg::ACC_W-1:0] num,
  input  logic signed [vtpd_pkg::ACC_W-1:0] den,
  output logic                             out_vld,
  output logic                             out_zro,
  output logic [vtpd_pkg::QUOT_W-1:0]      quot
);

  localparam int AW = vtpd_pkg::ACC_W;
  localparam int QW = vtpd_pkg::QUOT_W;
  localparam int FW = vtpd_pkg::FRAC_W;

  logic [AW-1:0]         rem  [0:QW];
  logic [AW-1:0]         dvs  [0:QW];
  logic [QW-1:0]         lo   [0:QW];
  vtpd_pkg::div_meta_t   meta [0:QW];

  logic [AW-1:0]         nmag;
  logic [AW-1:0]         dmag;
  logic                  ovf;
  logic [QW:0]           mag;
  logic [QW-1:0]         res;

  // magnitudes and overflow precheck
  always_comb begin
    nmag = num[AW-1] ? AW'(-num) : AW'(num);
    dmag = den[AW-1] ? AW'(-den) : AW'(den);
    if (dmag[AW-1:QW+1] != '0) begin
      ovf = 1'b0;
    end else begin
      ovf = nmag >= {dmag[AW-FW-1:0], {FW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta[0].vld <= 1'b0;
    end else if (en) begin
      meta[0].vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta[0].neg <= num[AW-1] ^ den[AW-1];
      meta[0].ovf <= ovf;
      meta[0].zro <= (den == '0);
      rem[0]      <= AW'(nmag[AW-1:FW]);
      lo[0]       <= {nmag[FW-1:0], {(QW-FW){1'b0}}};
      dvs[0]      <= dmag;
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [AW:0] t;
    logic        ge;

    always_comb begin
      t  = {rem[i], lo[i][QW-1]};
      ge = t >= {1'b0, dvs[i]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        meta[i+1].vld <= 1'b0;
      end else if (en) begin
        meta[i+1].vld <= meta[i].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta[i+1].neg <= meta[i].neg;
        meta[i+1].ovf <= meta[i].ovf;
        meta[i+1].zro <= meta[i].zro;
        rem[i+1]      <= ge ? AW'(t - {1'b0, dvs[i]}) : t[AW-1:0];
        lo[i+1]       <= {lo[i][QW-2:0], ge};
        dvs[i+1]      <= dvs[i];
      end
    end
  end

  // saturate and apply sign; a zero divisor gives a zero result
  always_comb begin
    mag = meta[QW].ovf ? {1'b1, {QW{1'b0}}} : {1'b0, lo[QW]};
    if (meta[QW].zro) begin
      res = '0;
    end else if (meta[QW].neg) begin
      res = (mag > {1'b0, vtpd_pkg::SAT_NEG}) ? vtpd_pkg::SAT_NEG : QW'(-mag);
    end else begin
      res = (mag > {1'b0, vtpd_pkg::SAT_POS}) ? vtpd_pkg::SAT_POS : mag[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= meta[QW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot    <= res;
      out_zro <= meta[QW].zro;
    end
  end

endmodule

### sv/vertex_transform_perspective_divide_unit.sv
// channel   | direction | handshake               | payload
// s_axis    | in        | s_axis_tvalid/tready    | pos x,y,z, nrm x,y,z
// m_axis    | out       | m_axis_tvalid/tready    | out pos/nrm x,y,z; w-zero flags
// cfg       | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data (matrix row)
//
// one vertex enters per cycle unless m_axis stalls; the stages are product, row sum,
// divider setup, 32 divider steps (one quotient bit each) and saturation.
// rst (synchronous) clears the valid bits and loads the identity matrix.
// a stall on m_axis freezes the whole pipeline; s_axis_tready follows it.
module vertex_transform_perspective_divide_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z (32 bits each)
  input  logic [191:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z
  output logic [191:0]  m_axis_tdata,
  // pos_w_zero, nrm_w_zero
  output logic [1:0]    m_axis_tuser,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [vtpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vtpd_pkg::ROW_W-1:0]     cfg_data
);

  localparam int NR = vtpd_pkg::NUM_ROWS;
  localparam int NC = vtpd_pkg::NUM_COLS;
  localparam int LW = vtpd_pkg::LANE_W;
  localparam int CW = vtpd_pkg::COORD_W;
  localparam int PW = vtpd_pkg::PROD_W;
  localparam int AW = vtpd_pkg::ACC_W;

  logic [vtpd_pkg::ROW_W-1:0] matrix [0:NR-1];
  logic                       en;
  logic                       v1;
  logic                       v2;
  logic signed [PW-1:0]       prod_p [0:NR-1][0:NC-1];
  logic signed [PW-1:0]       prod_n [0:NR-1][0:NC-1];
  logic signed [AW-1:0]       acc_p  [0:NR-1];
  logic signed [AW-1:0]       acc_n  [0:NR-1];
  logic [5:0]                 dv;
  logic [5:0]                 dz;

  assign cfg_ready     = 1'b1;
  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  // matrix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix[0] <= vtpd_pkg::ROW0_RST;
      matrix[1] <= vtpd_pkg::ROW1_RST;
      matrix[2] <= vtpd_pkg::ROW2_RST;
      matrix[3] <= vtpd_pkg::ROW3_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        vtpd_pkg::CFG_ROW0: matrix[0] <= cfg_data;
        vtpd_pkg::CFG_ROW1: matrix[1] <= cfg_data;
        vtpd_pkg::CFG_ROW2: matrix[2] <= cfg_data;
        vtpd_pkg::CFG_ROW3: matrix[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits for product and sum stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
    end
  end

  // coefficient times coordinate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NR; r++) begin
        for (int c = 0; c < NC; c++) begin
          prod_p[r][c] <= $signed(matrix[r][LW*c +: LW])
                          * $signed(s_axis_tdata[CW*c +: CW]);
          prod_n[r][c] <= $signed(matrix[r][LW*c +: LW])
                          * $signed(s_axis_tdata[CW*(c+NC) +: CW]);
        end
      end
    end
  end

  // row sums; the position adds the column 3 coefficient as w = 1
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NR; r++) begin
        acc_n[r] <= AW'(prod_n[r][0]) + AW'(prod_n[r][1]) + AW'(prod_n[r][2]);
        acc_p[r] <= AW'(prod_p[r][0]) + AW'(prod_p[r][1]) + AW'(prod_p[r][2])
                    + AW'($signed({matrix[r][LW*NC +: LW], 16'h0000}));
      end
    end
  end

  // one divider per output coordinate
  for (genvar k = 0; k < 2*NC; k++) begin : g_div
    logic signed [AW-1:0] num;
    logic signed [AW-1:0] den;

    assign num = (k < NC) ? acc_p[k % NC] : acc_n[k % NC];
    assign den = (k < NC) ? acc_p[NR-1]  : acc_n[NR-1];

    vtpd_div u_div (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (v2),
      .num     (num),
      .den     (den),
      .out_vld (dv[k]),
      .out_zro (dz[k]),
      .quot    (m_axis_tdata[CW*k +: CW])
    );
  end

  assign m_axis_tvalid = dv[0] & dv[NC];
  assign m_axis_tuser  = {dz[NC] & dz[NC+1] & dz[NC+2] & dv[5] & dv[4],
                          dz[0] & dz[1] & dz[2] & dv[1] & dv[2]};

endmodule
